// ===== rtl/sfs_pkg.sv =====
// Shared types, register indexes and codes for the sprite frame sequencer.
`default_nettype none
package sfs_pkg;

  localparam int FRAME_BITS = 8;
  localparam int TICK_BITS  = 24;

  localparam int FIELD_FRAME_BITS = 8;
  localparam int SIZE_BITS        = 11;
  localparam int ROW_BITS         = 8;
  localparam int TPF_BITS         = 24;
  localparam int LOOP_BITS        = 16;
  localparam int ORDER_BITS       = 2;
  localparam int MODE_BITS        = 2;
  localparam int RECT_BITS        = 18;
  localparam int CFG_INDEX_BITS   = 3;
  localparam int CFG_DATA_BITS    = 24;

  localparam logic [TPF_BITS-1:0] TPF_RESET = TPF_BITS'(30);

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_INDEX       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_FRAME     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_FRAME      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TICKS_PER_FRAME = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_LIMIT      = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PLAY_ORDER      = 3'd7;

  // Event codes.
  localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_PLAY  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_PAUSE = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_LOAD  = 2'd3;

  // Playback orders; the fourth code holds the frame.
  localparam logic [ORDER_BITS-1:0] ORDER_FWD  = 2'd0;
  localparam logic [ORDER_BITS-1:0] ORDER_REV  = 2'd1;
  localparam logic [ORDER_BITS-1:0] ORDER_PING = 2'd2;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [TICK_BITS-1:0]  tick_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  frame_width;
    logic [SIZE_BITS-1:0]  frame_height;
    logic [ROW_BITS-1:0]   row_index;
    logic [FIELD_FRAME_BITS-1:0] first_frame;
    logic [FIELD_FRAME_BITS-1:0] last_frame;
    logic [TPF_BITS-1:0]   ticks_per_frame;
    logic [LOOP_BITS-1:0]  loop_limit;
    logic [ORDER_BITS-1:0] play_order;
  } sfs_cfg_t;

  // Register file contents after reset.
  localparam sfs_cfg_t CFG_RESET = '{
    frame_width:     '0,
    frame_height:    '0,
    row_index:       '0,
    first_frame:     '0,
    last_frame:      '0,
    ticks_per_frame: TPF_RESET,
    loop_limit:      '0,
    play_order:      '0
  };

  typedef struct packed {
    frame_t               frame;
    tick_t                ticks;
    logic                 playing;
    logic [LOOP_BITS-1:0] loops;
    logic                 going_back;
  } sfs_state_t;

endpackage
`default_nettype wire

// ===== rtl/sfs_step.sv =====
// Next-state logic of the sequencer for one event.
`default_nettype none
module sfs_step
  import sfs_pkg::*;
(
  input  wire sfs_state_t       state_cur,
  input  wire sfs_cfg_t         cfg,
  input  wire logic [MODE_BITS-1:0]  mode,
  input  wire logic [FIELD_FRAME_BITS-1:0] frame_value,
  output sfs_state_t            state_nxt,
  output logic                  stepped
);

  localparam int CMP_BITS = (TICK_BITS > TPF_BITS) ? TICK_BITS : TPF_BITS;

  frame_t               lo;
  frame_t               hi;
  frame_t               target;
  logic                 gb_target;
  logic                 wrap;
  logic                 limit_on;
  logic                 limit_hit;
  logic [LOOP_BITS-1:0] loops_inc;
  tick_t                ticks_inc;

  always_comb begin
    lo        = FRAME_BITS'(cfg.first_frame);
    hi        = FRAME_BITS'(cfg.last_frame);
    loops_inc = (state_cur.loops != '1) ? state_cur.loops + LOOP_BITS'(1) : state_cur.loops;
    limit_on  = (cfg.loop_limit != '0);
    limit_hit = limit_on && (loops_inc >= cfg.loop_limit);
    ticks_inc = (state_cur.ticks != '1) ? state_cur.ticks + TICK_BITS'(1) : state_cur.ticks;

    // Candidate frame for a period step, and whether it is a loop wrap.
    wrap      = 1'b0;
    target    = state_cur.frame;
    gb_target = state_cur.going_back;
    case (cfg.play_order)
      ORDER_FWD: begin
        if (state_cur.frame >= hi) begin
          wrap   = 1'b1;
          target = lo;
        end else begin
          target = state_cur.frame + FRAME_BITS'(1);
        end
      end
      ORDER_REV: begin
        if (state_cur.frame <= lo) begin
          wrap   = 1'b1;
          target = hi;
        end else begin
          target = state_cur.frame - FRAME_BITS'(1);
        end
      end
      ORDER_PING: begin
        if (!state_cur.going_back) begin
          if (state_cur.frame >= hi) begin
            gb_target = 1'b1;
            target    = (hi != '0) ? hi - FRAME_BITS'(1) : '0;
          end else begin
            target = state_cur.frame + FRAME_BITS'(1);
          end
        end else begin
          if (state_cur.frame <= lo) begin
            wrap      = 1'b1;
            gb_target = 1'b0;
            target    = (lo != '1) ? lo + FRAME_BITS'(1) : lo;
          end else begin
            target = state_cur.frame - FRAME_BITS'(1);
          end
        end
      end
      default: begin
        target = state_cur.frame;
      end
    endcase

    state_nxt = state_cur;
    stepped   = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (state_cur.playing &&
            !(cfg.frame_width == '0 && cfg.frame_height == '0)) begin
          if (CMP_BITS'(ticks_inc) >= CMP_BITS'(cfg.ticks_per_frame)) begin
            state_nxt.ticks = '0;
            stepped         = 1'b1;
            if (wrap && limit_on) begin
              state_nxt.loops = loops_inc;
            end
            // Reaching the loop limit stops playback on the current frame.
            if (wrap && limit_hit) begin
              state_nxt.playing = 1'b0;
            end else begin
              state_nxt.frame      = target;
              state_nxt.going_back = gb_target;
            end
          end else begin
            state_nxt.ticks = ticks_inc;
          end
        end
      end
      MODE_PLAY: begin
        state_nxt.ticks   = '0;
        state_nxt.playing = 1'b1;
      end
      MODE_PAUSE: begin
        state_nxt.playing = 1'b0;
      end
      MODE_LOAD: begin
        state_nxt.frame = FRAME_BITS'(frame_value);
      end
      default: begin
        state_nxt = state_cur;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sprite_frame_sequencer.sv =====
// Top level of the sprite animation frame sequencer with register file and pipeline.
// Path: an accepted word goes into the input register, then moves into the output register and state as the pipe moves.
// Throughput: one word per cycle while the output is not stalled; the state update loop sets this rate.
// The output register and the input register let a new word enter while a result waits.
// Reset (synchronous, rst_n low) stops playback, zeroes frame, ticks, loop count and
// direction, and loads register defaults (ticks_per_frame 30, all others zero).
`default_nettype none
module sprite_frame_sequencer
  import sfs_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [MODE_BITS-1:0]        in_mode,
  input  wire logic [FIELD_FRAME_BITS-1:0] in_frame_value,

  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [FIELD_FRAME_BITS-1:0]      out_frame_index,
  output logic [RECT_BITS-1:0]             out_rect_x,
  output logic [RECT_BITS-1:0]             out_rect_y,
  output logic                             out_is_playing,
  output logic                             out_stepped,

  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]    cfg_data
);

  // Configuration registers. Writes are always taken; the host writes only
  // while the sequencer is idle.
  sfs_cfg_t cfg_r;
  sfs_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:     cfg_nxt.frame_width     = cfg_data[SIZE_BITS-1:0];
        REG_FRAME_HEIGHT:    cfg_nxt.frame_height    = cfg_data[SIZE_BITS-1:0];
        REG_ROW_INDEX:       cfg_nxt.row_index       = cfg_data[ROW_BITS-1:0];
        REG_FIRST_FRAME:     cfg_nxt.first_frame     = cfg_data[FIELD_FRAME_BITS-1:0];
        REG_LAST_FRAME:      cfg_nxt.last_frame      = cfg_data[FIELD_FRAME_BITS-1:0];
        REG_TICKS_PER_FRAME: cfg_nxt.ticks_per_frame = cfg_data[TPF_BITS-1:0];
        REG_LOOP_LIMIT:      cfg_nxt.loop_limit      = cfg_data[LOOP_BITS-1:0];
        REG_PLAY_ORDER:      cfg_nxt.play_order      = cfg_data[ORDER_BITS-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline control. The whole pipe moves whenever the output register is
  // empty or its word is being taken; the input register stalls the
  // upstream side only when it is full and the pipe cannot move.
  logic                        s1_valid_r;
  logic [MODE_BITS-1:0]        s1_mode_r;
  logic [FIELD_FRAME_BITS-1:0] s1_frame_value_r;
  logic                        out_valid_r;
  logic                        out_stepped_r;
  logic                        pipe_move;
  logic                        s1_load;
  logic                        update;

  assign pipe_move = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !pipe_move;
  assign s1_load   = in_valid && !in_stall;
  assign update    = s1_valid_r && pipe_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || pipe_move) begin
      s1_valid_r <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_mode_r        <= in_mode;
      s1_frame_value_r <= in_frame_value;
    end
  end

  // Sequencer state advances exactly when a word moves into the output
  // register, so the state always matches the word on display.
  sfs_state_t state_r;
  sfs_state_t state_nxt;
  logic       stepped_nxt;

  sfs_step u_step (
    .state_cur   (state_r),
    .cfg         (cfg_r),
    .mode        (s1_mode_r),
    .frame_value (s1_frame_value_r),
    .state_nxt   (state_nxt),
    .stepped     (stepped_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (update) begin
        state_r <= state_nxt;
      end
      if (pipe_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_stepped_r <= stepped_nxt;
    end
  end

  // The rectangle origin is formed from registered values after the state
  // register, so it holds steady while the output word is stalled, as long as the configuration is not written.
  logic [FRAME_BITS+SIZE_BITS-1:0] rect_x_full;
  logic [ROW_BITS+SIZE_BITS-1:0]   rect_y_full;

  assign rect_x_full = (FRAME_BITS+SIZE_BITS)'(state_r.frame) *
                       (FRAME_BITS+SIZE_BITS)'(cfg_r.frame_width);
  assign rect_y_full = (ROW_BITS+SIZE_BITS)'(cfg_r.row_index) *
                       (ROW_BITS+SIZE_BITS)'(cfg_r.frame_height);

  assign out_valid       = out_valid_r;
  assign out_frame_index = FIELD_FRAME_BITS'(state_r.frame);
  assign out_rect_x      = RECT_BITS'(rect_x_full);
  assign out_rect_y      = RECT_BITS'(rect_y_full);
  assign out_is_playing  = state_r.playing;
  assign out_stepped     = out_stepped_r;

`ifndef NO_ASSERTIONS
  // The input side is held off only while the input register is occupied.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  // Without a word moving forward, the sequencer state must not change.
  a_state_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    !update |=> $stable(state_r))
    else $error("sequencer state changed without an event");

  // A period step always restarts the tick counter.
  a_step_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (update && stepped_nxt) |=> (state_r.ticks == '0))
    else $error("tick counter not cleared on a frame step");

  // The loop count only ever grows outside reset.
  a_loops_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (state_r.loops >= $past(state_r.loops)))
    else $error("loop count decreased");

  // A reported step belongs to a tick event that was counted while playing.
  a_step_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    stepped_nxt |-> (s1_mode_r == MODE_TICK && state_r.playing))
    else $error("step reported for a non-tick event");
`endif

endmodule
`default_nettype wire
